// ===== src/mrm_pkg.sv =====
// Shared types, constants and helper functions for the memory region map merger.
`default_nettype none
package mrm_pkg;

  // Default sizes for the top level parameters
  localparam int MAP_DEPTH_DEF = 32;
  localparam int ADDR_BITS_DEF = 48;

  // Fixed field widths
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BITS  = 37;
  localparam int TYPE_BITS  = 4;
  localparam int BASE_W     = 48;
  localparam int LEN_W      = 49;
  localparam int KIND_W     = 32;
  localparam int IDX_W      = 5;
  localparam int TOTAL_W    = 6;

  // Stream layout: slave tdata
  localparam int IN_DATA_W  = 136;
  localparam int IN_BASE_LO = 0;
  localparam int IN_LEN_LO  = 48;
  localparam int IN_KIND_LO = 97;
  localparam int IN_FORCE   = 129;
  localparam int IN_IDX_LO  = 130;

  // Stream layout: master tdata
  localparam int OUT_DATA_W   = 96;
  localparam int OUT_BASE_LO  = 0;
  localparam int OUT_PAGES_LO = 48;
  localparam int OUT_TYPE_LO  = 85;
  localparam int OUT_TOTAL_LO = 89;

  localparam logic [PAGE_BITS-1:0] PAGES_MAX = '1;
  localparam logic [PAGE_SHIFT-1:0] PAGE_MASK = '1;

  // UEFI memory types used here
  localparam logic [TYPE_BITS-1:0] UEFI_RT_DATA  = 4'd6;
  localparam logic [TYPE_BITS-1:0] UEFI_CONV     = 4'd7;
  localparam logic [TYPE_BITS-1:0] UEFI_UNUSABLE = 4'd8;
  localparam logic [TYPE_BITS-1:0] UEFI_ACPI_RCL = 4'd9;
  localparam logic [TYPE_BITS-1:0] UEFI_ACPI_NVS = 4'd10;

  // Raw firmware region kinds
  localparam logic [KIND_W-1:0] KIND_RAM      = 32'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 32'd2;
  localparam logic [KIND_W-1:0] KIND_ACPI     = 32'd3;
  localparam logic [KIND_W-1:0] KIND_NVS      = 32'd4;
  localparam logic [KIND_W-1:0] KIND_UNUSABLE = 32'd5;
  localparam logic [KIND_W-1:0] KIND_VENDOR   = 32'd6;
  localparam logic [KIND_W-1:0] KIND_TABLE    = 32'd16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD   = 2'd0,
    ALU_SUB   = 2'd1,
    ALU_ADDM1 = 2'd2
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDGET,
    S_PREP1,
    S_PREP2,
    S_PREP3,
    S_PREP4,
    S_LCALC,
    S_LOOP,
    S_FETCH,
    S_CMP,
    S_W_RP,
    S_W_LP,
    S_W_TAIL,
    S_L_LP,
    S_L_NP,
    S_FINAL,
    S_INS,
    S_INS_RD,
    S_INS_WR,
    S_RM_RD,
    S_RM_WR,
    S_OUT
  } state_t;

  // Raw kind to {known, UEFI type}
  function automatic logic [TYPE_BITS:0] map_kind(input logic [KIND_W-1:0] kind);
    logic [TYPE_BITS:0] r;
    begin
      priority case (kind)
        KIND_RAM:      r = {1'b1, UEFI_CONV};
        KIND_RESERVED: r = {1'b1, UEFI_RT_DATA};
        KIND_ACPI:     r = {1'b1, UEFI_ACPI_RCL};
        KIND_NVS:      r = {1'b1, UEFI_ACPI_NVS};
        KIND_UNUSABLE: r = {1'b1, UEFI_UNUSABLE};
        KIND_VENDOR:   r = {1'b1, UEFI_RT_DATA};
        KIND_TABLE:    r = {1'b1, UEFI_RT_DATA};
        default:       r = '0;
      endcase
      return r;
    end
  endfunction

  // Types that firmware keeps for good
  function automatic logic is_permanent(input logic [TYPE_BITS-1:0] t);
    return (t == 4'd5) || (t == 4'd6) || (t == 4'd8) || (t == 4'd10) ||
           (t == 4'd11) || (t == 4'd12) || (t == 4'd13);
  endfunction

endpackage
`default_nettype wire

// ===== src/mrm_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module mrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mrm_alu.sv =====
// Shared adder/subtractor used by the merge sequencer.
`default_nettype none
module mrm_alu #(
  parameter int WW = 50
) (
  input  wire logic [1:0]    op,
  input  wire logic [WW-1:0] a,
  input  wire logic [WW-1:0] b,
  output logic      [WW-1:0] r
);

  always_comb begin
    unique case (op)
      mrm_pkg::ALU_ADD:   r = a + b;
      mrm_pkg::ALU_SUB:   r = a - b;
      mrm_pkg::ALU_ADDM1: r = a + b - WW'(1);
      default:            r = a;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/memory_region_map_merge.sv =====
// Top level: sorted memory region table with merge sequencer.
//
//  group  | dir | tdata fields (low bit up)                       | tuser
//  s_axis | in  | region_base, region_length, region_kind,        | opcode
//         |     | force_win, entry_index                          |
//  m_axis | out | entry_base, entry_pages, entry_type, entry_total | status
//
// One transfer in, one transfer out. An add walks the table entry by entry,
// using the single shared adder and the single-write-port table RAM, and
// each insert or remove moves the later entries one at a time.
// Reset empties the table (count cleared, no RAM sweep). s_tready is high
// only while idle; a finished result waits in the output register.
`default_nettype none
module memory_region_map_merge #(
  parameter int MAP_DEPTH = mrm_pkg::MAP_DEPTH_DEF,
  parameter int ADDR_BITS = mrm_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // base[47:0], length[96:48], kind[128:97], force_win[129], entry_index[134:130]
  input  wire logic [mrm_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // entry_base[47:0], entry_pages[84:48], entry_type[88:85], entry_total[94:89]
  output logic      [mrm_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic      [1:0]                      m_tuser
);

  localparam int WW = ((ADDR_BITS > 49) ? ADDR_BITS : 49) + 1;
  localparam int AW = $clog2(MAP_DEPTH);
  localparam int CW = $clog2(MAP_DEPTH + 1);
  localparam int IW = (CW > mrm_pkg::IDX_W) ? CW : mrm_pkg::IDX_W;
  localparam int PB = mrm_pkg::PAGE_BITS;
  localparam int TB = mrm_pkg::TYPE_BITS;
  localparam int BW = mrm_pkg::BASE_W;
  localparam int EW = ADDR_BITS + PB + TB;
  localparam int PS = mrm_pkg::PAGE_SHIFT;
  localparam logic [WW-1:0] ADDR_MASK = WW'((66'd1 << ADDR_BITS) - 66'd1);

  // Input field split
  logic [BW-1:0]                in_base;
  logic [mrm_pkg::LEN_W-1:0]    in_len;
  logic [mrm_pkg::KIND_W-1:0]   in_kind;
  logic                         in_force;
  logic [mrm_pkg::IDX_W-1:0]    in_idx;
  logic [TB:0]                  kind_map;

  assign in_base  = s_tdata[mrm_pkg::IN_BASE_LO +: BW];
  assign in_len   = s_tdata[mrm_pkg::IN_LEN_LO +: mrm_pkg::LEN_W];
  assign in_kind  = s_tdata[mrm_pkg::IN_KIND_LO +: mrm_pkg::KIND_W];
  assign in_force = s_tdata[mrm_pkg::IN_FORCE];
  assign in_idx   = s_tdata[mrm_pkg::IN_IDX_LO +: mrm_pkg::IDX_W];
  assign kind_map = mrm_pkg::map_kind(in_kind);

  // Sequencer registers
  mrm_pkg::state_t  state, state_next, ret, ret_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    i, i_next, k, k_next, ins_at, ins_at_next;
  logic             ins_bump, ins_bump_next;
  logic [WW-1:0]    b, b_next, pg, pg_next, l, l_next;
  logic [WW-1:0]    es, es_next, el, el_next, tmp, tmp_next;
  logic [TB-1:0]    et, et_next, ty, ty_next;
  logic             force_r, force_next, perm, perm_next, bad, bad_next;
  logic [WW-1:0]    ins_start, ins_start_next;
  logic [PB-1:0]    ins_pages, ins_pages_next;
  logic [TB-1:0]    ins_type, ins_type_next;
  logic [1:0]       res_status, res_status_next;
  logic [BW-1:0]    res_base, res_base_next;
  logic [PB-1:0]    res_pages, res_pages_next;
  logic [TB-1:0]    res_type, res_type_next;
  logic             out_valid, out_valid_next;
  logic [1:0]       out_status, out_status_next;
  logic [mrm_pkg::OUT_DATA_W-1:0] out_data, out_data_next;

  // Shared adder and table RAM hookup
  logic [1:0]       alu_op;
  logic [WW-1:0]    alu_a, alu_b, alu_r, diff_pages;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] rd_start;
  logic [PB-1:0]    rd_pages;
  logic [TB-1:0]    rd_type;
  logic [CW-1:0]    k_dec, k_inc, i_inc;
  logic [WW-1:0]    pg_clip;

  assign rd_start   = ram_rdata[0 +: ADDR_BITS];
  assign rd_pages   = ram_rdata[ADDR_BITS +: PB];
  assign rd_type    = ram_rdata[ADDR_BITS + PB +: TB];
  assign diff_pages = alu_r >> PS;
  assign k_dec      = k - CW'(1);
  assign k_inc      = k + CW'(1);
  assign i_inc      = i + CW'(1);

  mrm_alu #(.WW(WW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .r  (alu_r)
  );

  mrm_ram #(.WIDTH(EW), .DEPTH(MAP_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == mrm_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrm_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ret        <= ret_next;
    i          <= i_next;
    k          <= k_next;
    ins_at     <= ins_at_next;
    ins_bump   <= ins_bump_next;
    b          <= b_next;
    pg         <= pg_next;
    l          <= l_next;
    es         <= es_next;
    el         <= el_next;
    tmp        <= tmp_next;
    et         <= et_next;
    ty         <= ty_next;
    force_r    <= force_next;
    perm       <= perm_next;
    bad        <= bad_next;
    ins_start  <= ins_start_next;
    ins_pages  <= ins_pages_next;
    ins_type   <= ins_type_next;
    res_status <= res_status_next;
    res_base   <= res_base_next;
    res_pages  <= res_pages_next;
    res_type   <= res_type_next;
    out_status <= out_status_next;
    out_data   <= out_data_next;
  end

  // Next state, datapath control
  always_comb begin
    state_next      = state;
    ret_next        = ret;
    count_next      = count;
    i_next          = i;
    k_next          = k;
    ins_at_next     = ins_at;
    ins_bump_next   = ins_bump;
    b_next          = b;
    pg_next         = pg;
    l_next          = l;
    es_next         = es;
    el_next         = el;
    tmp_next        = tmp;
    et_next         = et;
    ty_next         = ty;
    force_next      = force_r;
    perm_next       = perm;
    bad_next        = bad;
    ins_start_next  = ins_start;
    ins_pages_next  = ins_pages;
    ins_type_next   = ins_type;
    res_status_next = res_status;
    res_base_next   = res_base;
    res_pages_next  = res_pages;
    res_type_next   = res_type;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_data_next   = out_data;
    alu_op          = mrm_pkg::ALU_ADD;
    alu_a           = '0;
    alu_b           = '0;
    ram_we          = 1'b0;
    ram_waddr       = i[AW-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = i[AW-1:0];
    pg_clip         = pg;

    // output register drains independently
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      mrm_pkg::S_IDLE: begin
        ram_raddr = AW'(in_idx);
        if (s_tvalid) begin
          res_status_next = mrm_pkg::ST_OK;
          res_base_next   = '0;
          res_pages_next  = '0;
          res_type_next   = '0;
          b_next          = WW'(in_base);
          tmp_next        = WW'(in_len);
          ty_next         = kind_map[TB-1:0];
          bad_next        = !kind_map[TB] || (WW'(in_base) > ADDR_MASK);
          force_next      = in_force;
          perm_next       = mrm_pkg::is_permanent(kind_map[TB-1:0]);
          unique case (mrm_pkg::opcode_t'(s_tuser))
            mrm_pkg::OP_ADD: state_next = mrm_pkg::S_PREP1;
            mrm_pkg::OP_READ: begin
              if (IW'(in_idx) < IW'(count)) begin
                state_next = mrm_pkg::S_RDGET;
              end else begin
                res_status_next = mrm_pkg::ST_RANGE;
                state_next      = mrm_pkg::S_OUT;
              end
            end
            mrm_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = mrm_pkg::S_OUT;
            end
            default: state_next = mrm_pkg::S_OUT;
          endcase
        end
      end

      mrm_pkg::S_RDGET: begin
        res_base_next  = BW'(rd_start);
        res_pages_next = rd_pages;
        res_type_next  = rd_type;
        state_next     = mrm_pkg::S_OUT;
      end

      // length rounded up to pages
      mrm_pkg::S_PREP1: begin
        alu_op     = mrm_pkg::ALU_ADD;
        alu_a      = tmp;
        alu_b      = WW'(mrm_pkg::PAGE_MASK);
        pg_next    = alu_r >> PS;
        state_next = mrm_pkg::S_PREP2;
      end

      // room left below the top of the address space
      mrm_pkg::S_PREP2: begin
        alu_op   = mrm_pkg::ALU_SUB;
        alu_a    = ADDR_MASK;
        alu_b    = b;
        tmp_next = alu_r;
        if (bad || (pg == '0)) begin
          res_status_next = mrm_pkg::ST_SKIP;
          state_next      = mrm_pkg::S_OUT;
        end else begin
          state_next = mrm_pkg::S_PREP3;
        end
      end

      mrm_pkg::S_PREP3: begin
        alu_op     = mrm_pkg::ALU_ADD;
        alu_a      = tmp >> PS;
        alu_b      = WW'(tmp[PS-1:0] == mrm_pkg::PAGE_MASK);
        tmp_next   = alu_r;
        state_next = mrm_pkg::S_PREP4;
      end

      // clip page count
      mrm_pkg::S_PREP4: begin
        if (tmp < pg_clip) begin
          pg_clip = tmp;
        end
        if (pg_clip > WW'(mrm_pkg::PAGES_MAX)) begin
          pg_clip = WW'(mrm_pkg::PAGES_MAX);
        end
        pg_next = pg_clip;
        i_next  = '0;
        if (pg_clip == '0) begin
          res_status_next = mrm_pkg::ST_SKIP;
          state_next      = mrm_pkg::S_OUT;
        end else begin
          state_next = mrm_pkg::S_LCALC;
        end
      end

      // last byte of the new region
      mrm_pkg::S_LCALC: begin
        alu_op     = mrm_pkg::ALU_ADDM1;
        alu_a      = b;
        alu_b      = pg << PS;
        l_next     = alu_r;
        state_next = mrm_pkg::S_LOOP;
      end

      mrm_pkg::S_LOOP: begin
        ram_raddr = i[AW-1:0];
        if (i < count) begin
          state_next = mrm_pkg::S_FETCH;
        end else begin
          state_next = mrm_pkg::S_FINAL;
        end
      end

      // entry i arrives; its last byte through the adder
      mrm_pkg::S_FETCH: begin
        alu_op     = mrm_pkg::ALU_ADDM1;
        alu_a      = WW'(rd_start);
        alu_b      = WW'(rd_pages) << PS;
        es_next    = WW'(rd_start);
        et_next    = rd_type;
        el_next    = alu_r;
        state_next = mrm_pkg::S_CMP;
      end

      // overlap classification
      mrm_pkg::S_CMP: begin
        if (el < b) begin
          i_next     = i_inc;
          state_next = mrm_pkg::S_LOOP;
        end else if (es > l) begin
          state_next = mrm_pkg::S_FINAL;
        end else if (force_r || (et == mrm_pkg::UEFI_CONV) || perm) begin
          if (es < b) begin
            state_next = (el > l) ? mrm_pkg::S_W_RP : mrm_pkg::S_W_LP;
          end else if (el > l) begin
            state_next = mrm_pkg::S_W_TAIL;
          end else begin
            k_next     = i;
            state_next = mrm_pkg::S_RM_RD;
          end
        end else begin
          state_next = (b < es) ? mrm_pkg::S_L_LP : mrm_pkg::S_L_NP;
        end
      end

      // split: upper remainder of the old entry goes in after it
      mrm_pkg::S_W_RP: begin
        alu_op = mrm_pkg::ALU_SUB;
        alu_a  = el;
        alu_b  = l;
        if (diff_pages != '0) begin
          ins_at_next    = i_inc;
          ins_start_next = l + WW'(1);
          ins_pages_next = diff_pages[PB-1:0];
          ins_type_next  = et;
          ins_bump_next  = 1'b0;
          ret_next       = mrm_pkg::S_W_LP;
          state_next     = mrm_pkg::S_INS;
        end else begin
          state_next = mrm_pkg::S_W_LP;
        end
      end

      // keep lower part of the old entry
      mrm_pkg::S_W_LP: begin
        alu_op    = mrm_pkg::ALU_SUB;
        alu_a     = b;
        alu_b     = es;
        ram_waddr = i[AW-1:0];
        ram_wdata = {et, diff_pages[PB-1:0], es[ADDR_BITS-1:0]};
        if (diff_pages != '0) begin
          ram_we     = 1'b1;
          i_next     = i_inc;
          state_next = mrm_pkg::S_LOOP;
        end else begin
          k_next     = i;
          state_next = mrm_pkg::S_RM_RD;
        end
      end

      // keep upper part of the old entry
      mrm_pkg::S_W_TAIL: begin
        alu_op    = mrm_pkg::ALU_SUB;
        alu_a     = el;
        alu_b     = l;
        ram_waddr = i[AW-1:0];
        ram_wdata = {et, diff_pages[PB-1:0], ADDR_BITS'(l + WW'(1))};
        if (diff_pages != '0) begin
          ram_we     = 1'b1;
          state_next = mrm_pkg::S_LOOP;
        end else begin
          k_next     = i;
          state_next = mrm_pkg::S_RM_RD;
        end
      end

      // old entry wins: new piece below it goes in first
      mrm_pkg::S_L_LP: begin
        alu_op = mrm_pkg::ALU_SUB;
        alu_a  = es;
        alu_b  = b;
        if (diff_pages != '0) begin
          ins_at_next    = i;
          ins_start_next = b;
          ins_pages_next = diff_pages[PB-1:0];
          ins_type_next  = ty;
          ins_bump_next  = 1'b1;
          ret_next       = mrm_pkg::S_L_NP;
          state_next     = mrm_pkg::S_INS;
        end else begin
          state_next = mrm_pkg::S_L_NP;
        end
      end

      // carry on with what sticks out above the old entry
      mrm_pkg::S_L_NP: begin
        alu_op = mrm_pkg::ALU_SUB;
        alu_a  = l;
        alu_b  = el;
        if ((l <= el) || (diff_pages == '0)) begin
          state_next = mrm_pkg::S_OUT;
        end else begin
          b_next     = el + WW'(1);
          pg_next    = diff_pages;
          i_next     = i_inc;
          state_next = mrm_pkg::S_LCALC;
        end
      end

      mrm_pkg::S_FINAL: begin
        ins_at_next    = i;
        ins_start_next = b;
        ins_pages_next = pg[PB-1:0];
        ins_type_next  = ty;
        ins_bump_next  = 1'b0;
        ret_next       = mrm_pkg::S_OUT;
        state_next     = mrm_pkg::S_INS;
      end

      // insert: full check, then shift up from the end
      mrm_pkg::S_INS: begin
        k_next = count;
        if (count == CW'(MAP_DEPTH)) begin
          res_status_next = mrm_pkg::ST_FULL;
          state_next      = mrm_pkg::S_OUT;
        end else begin
          state_next = mrm_pkg::S_INS_RD;
        end
      end

      mrm_pkg::S_INS_RD: begin
        ram_raddr = k_dec[AW-1:0];
        ram_waddr = ins_at[AW-1:0];
        ram_wdata = {ins_type, ins_pages, ins_start[ADDR_BITS-1:0]};
        if (k > ins_at) begin
          state_next = mrm_pkg::S_INS_WR;
        end else begin
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          if (ins_bump) begin
            i_next = i_inc;
          end
          state_next = ret;
        end
      end

      mrm_pkg::S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = k[AW-1:0];
        ram_wdata  = ram_rdata;
        k_next     = k_dec;
        state_next = mrm_pkg::S_INS_RD;
      end

      // remove: shift down over entry k
      mrm_pkg::S_RM_RD: begin
        ram_raddr = k_inc[AW-1:0];
        if (k_inc < count) begin
          state_next = mrm_pkg::S_RM_WR;
        end else begin
          count_next = count - CW'(1);
          state_next = mrm_pkg::S_LOOP;
        end
      end

      mrm_pkg::S_RM_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = k[AW-1:0];
        ram_wdata  = ram_rdata;
        k_next     = k_inc;
        state_next = mrm_pkg::S_RM_RD;
      end

      // hand result to the output register once it is free
      mrm_pkg::S_OUT: begin
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_data_next   = '0;
          out_data_next[mrm_pkg::OUT_BASE_LO +: BW]  = res_base;
          out_data_next[mrm_pkg::OUT_PAGES_LO +: PB] = res_pages;
          out_data_next[mrm_pkg::OUT_TYPE_LO +: TB]  = res_type;
          out_data_next[mrm_pkg::OUT_TOTAL_LO +: mrm_pkg::TOTAL_W] =
            mrm_pkg::TOTAL_W'(count);
          state_next = mrm_pkg::S_IDLE;
        end
      end

      default: state_next = mrm_pkg::S_IDLE;
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAP_DEPTH))
    else $error("table count above depth");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == mrm_pkg::ST_FULL)) |->
    (m_tdata[mrm_pkg::OUT_TOTAL_LO +: mrm_pkg::TOTAL_W] ==
     mrm_pkg::TOTAL_W'(MAP_DEPTH)))
    else $error("full status with table not full");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == mrm_pkg::ST_RANGE)) |->
    (m_tdata[mrm_pkg::OUT_TOTAL_LO-1:0] == '0))
    else $error("out of range read returned entry data");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready while an item is in work");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the memory region map merger.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import mrm_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [63:0] TOP_ADDR = 64'hFFFF_FFFF_FFFF;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] base;
    logic [48:0] len;
    logic [31:0] kind;
    logic        force_win;
    logic [4:0]  idx;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] base;
    logic [36:0] pages;
    logic [3:0]  etype;
    logic [5:0]  total;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  memory_region_map_merge uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the region table
  logic [63:0] shd_start [DEPTH+1];
  logic [63:0] shd_pages [DEPTH+1];
  logic [3:0]  shd_type  [DEPTH+1];
  int unsigned shd_count;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    mismatches = 0;
  int    send_idle_pct = 7;
  int    recv_idle_pct = 53;
  bit    recv_hold = 1'b0;
  bit    send_pause = 1'b0;

  function automatic bit shd_insert(int unsigned at, logic [63:0] st, logic [63:0] pg,
                                    logic [3:0] ty);
    if (shd_count >= DEPTH || at > shd_count) return 1'b0;
    for (int unsigned k = shd_count; k > at; k--) begin
      shd_start[k] = shd_start[k-1];
      shd_pages[k] = shd_pages[k-1];
      shd_type[k]  = shd_type[k-1];
    end
    shd_start[at] = st;
    shd_pages[at] = pg;
    shd_type[at]  = ty;
    shd_count++;
    return 1'b1;
  endfunction

  function automatic void shd_remove(int unsigned at);
    if (at >= shd_count) return;
    for (int unsigned k = at; k + 1 < shd_count; k++) begin
      shd_start[k] = shd_start[k+1];
      shd_pages[k] = shd_pages[k+1];
      shd_type[k]  = shd_type[k+1];
    end
    shd_count--;
  endfunction

  function automatic bit keeps_type(logic [3:0] t);
    return t == 5 || t == 6 || t == 8 || t == 10 || t == 11 || t == 12 || t == 13;
  endfunction

  // Merge one region into the shadow table, returns the add status
  function automatic status_t merge_region(logic [63:0] b, logic [63:0] pg, logic [3:0] ty,
                                           bit frc);
    logic [63:0] l, es, el, rp, lp, np;
    int unsigned i;
    bit win;
    l = b + (pg << 12) - 1;
    i = 0;
    while (i < shd_count) begin
      es = shd_start[i];
      el = es + (shd_pages[i] << 12) - 1;
      if (el < b) begin
        i++;
        continue;
      end
      if (es > l) break;
      win = frc || shd_type[i] == UEFI_CONV || keeps_type(ty);
      if (win) begin
        if (es < b) begin
          if (el > l) begin
            rp = (el - l) >> 12;
            if (rp != 0 && !shd_insert(i + 1, l + 1, rp, shd_type[i])) return ST_FULL;
          end
          lp = (b - es) >> 12;
          if (lp != 0) begin
            shd_pages[i] = lp;
            i++;
          end else shd_remove(i);
        end else if (el > l) begin
          rp = (el - l) >> 12;
          if (rp != 0) begin
            shd_start[i] = l + 1;
            shd_pages[i] = rp;
          end else shd_remove(i);
        end else shd_remove(i);
      end else begin
        if (b < es) begin
          lp = (es - b) >> 12;
          if (lp != 0) begin
            if (!shd_insert(i, b, lp, ty)) return ST_FULL;
            i++;
          end
        end
        if (l <= el) return ST_OK;
        np = (l - el) >> 12;
        if (np == 0) return ST_OK;
        b = el + 1;
        pg = np;
        l = b + (pg << 12) - 1;
        i++;
      end
    end
    if (!shd_insert(i, b, pg, ty)) return ST_FULL;
    return ST_OK;
  endfunction

  function automatic resp_t predict_resp(req_t r);
    resp_t o;
    logic [63:0] pg, span, maxp;
    logic [3:0] ty;
    bit known;
    o = '0;
    o.status = ST_OK;
    case (opcode_t'(r.op))
      OP_ADD: begin
        known = 1'b1;
        ty = '0;
        case (r.kind)
          KIND_RAM:      ty = UEFI_CONV;
          KIND_RESERVED: ty = UEFI_RT_DATA;
          KIND_ACPI:     ty = UEFI_ACPI_RCL;
          KIND_NVS:      ty = UEFI_ACPI_NVS;
          KIND_UNUSABLE: ty = UEFI_UNUSABLE;
          KIND_VENDOR:   ty = UEFI_RT_DATA;
          KIND_TABLE:    ty = UEFI_RT_DATA;
          default:       known = 1'b0;
        endcase
        pg = ({15'd0, r.len} + 64'd4095) >> 12;
        if (!known || pg == 0) o.status = ST_SKIP;
        else begin
          span = TOP_ADDR - {16'd0, r.base};
          maxp = (span >> 12) + ((span[11:0] == 12'hFFF) ? 64'd1 : 64'd0);
          if (pg > maxp) pg = maxp;
          if (pg > 64'h1F_FFFF_FFFF) pg = 64'h1F_FFFF_FFFF;
          if (pg == 0) o.status = ST_SKIP;
          else o.status = merge_region({16'd0, r.base}, pg, ty, r.force_win);
        end
      end
      OP_READ: begin
        if (r.idx < shd_count) begin
          o.base  = shd_start[r.idx][47:0];
          o.pages = shd_pages[r.idx][36:0];
          o.etype = shd_type[r.idx];
        end else o.status = ST_RANGE;
      end
      OP_CLEAR: shd_count = 0;
      default: ;
    endcase
    o.total = shd_count[5:0];
    return o;
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() > 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        s_tdata  <= {1'b0, r.idx, r.force_win, r.kind, r.len, r.base};
        s_tuser  <= r.op;
        s_tvalid <= 1'b1;
        expected_resps.push_back(predict_resp(r));
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready generation
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      resp_t got, exp;
      got.status = m_tuser;
      got.base   = m_tdata[47:0];
      got.pages  = m_tdata[84:48];
      got.etype  = m_tdata[88:85];
      got.total  = m_tdata[94:89];
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp = expected_resps.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: st %0d/%0d base %h/%h pg %h/%h ty %0d/%0d tot %0d/%0d",
                     exp.status, got.status, exp.base, got.base, exp.pages, got.pages,
                     exp.etype, got.etype, exp.total, got.total);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic req_t mk_add(logic [47:0] b, logic [48:0] n, logic [31:0] k, bit f);
    req_t r;
    r = '0;
    r.op = OP_ADD;
    r.base = b;
    r.len = n;
    r.kind = k;
    r.force_win = f;
    r.idx = 5'($urandom);
    return r;
  endfunction

  function automatic req_t mk_other(opcode_t op, logic [4:0] i);
    req_t r;
    r = '0;
    r.op = op;
    r.idx = i;
    r.base = 48'({$urandom, $urandom});
    r.len = 49'({$urandom, $urandom, $urandom});
    r.kind = $urandom;
    r.force_win = 1'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pick_kind();
    case ($urandom_range(9))
      0: return KIND_RAM;
      1: return KIND_RESERVED;
      2: return KIND_ACPI;
      3: return KIND_NVS;
      4: return KIND_UNUSABLE;
      5: return KIND_VENDOR;
      6: return KIND_TABLE;
      7: return KIND_RAM;
      8: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // Mostly clustered regions in a small window so they overlap a lot
  function automatic req_t rand_req();
    logic [47:0] b;
    logic [48:0] n;
    int sel;
    sel = $urandom_range(99);
    if (sel < 62) begin
      b = 48'($urandom_range(255)) << 12;
      if ($urandom_range(3) == 0) b = b + 48'($urandom_range(4095));
      n = 49'($urandom_range(24)) << 12;
      if ($urandom_range(3) == 0) n = n + 49'($urandom_range(4095)) - 49'd2048;
      if ($urandom_range(15) == 0) b = b | {1'b1, 47'($urandom_range(7)) << 44};
      return mk_add(b, n, pick_kind(), $urandom_range(5) == 0);
    end else if (sel < 66) begin
      b = 48'({$urandom, $urandom});
      n = 49'({$urandom, $urandom, $urandom});
      return mk_add(b, n, pick_kind(), 1'($urandom));
    end else if (sel < 97) begin
      return mk_other(OP_READ, 5'($urandom));
    end else if (sel < 98) begin
      return mk_other(OP_NOP, 5'($urandom));
    end
    return mk_other(OP_CLEAR, 5'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    shd_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each kind, overlaps, splits, range limits
    pending_reqs.push_back(mk_other(OP_READ, 5'd0));
    pending_reqs.push_back(mk_add(48'h10000, 49'd0, KIND_RAM, 1'b0));
    pending_reqs.push_back(mk_add(48'h10000, 49'h1000, 32'd7, 1'b0));
    pending_reqs.push_back(mk_add(48'h10000, 49'h1000, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk_add(48'h0, 49'h100000, KIND_RAM, 1'b0));
    pending_reqs.push_back(mk_add(48'h20000, 49'h2000, KIND_RESERVED, 1'b0));
    pending_reqs.push_back(mk_add(48'h40800, 49'h1800, KIND_ACPI, 1'b0));
    pending_reqs.push_back(mk_add(48'h60000, 49'h1, KIND_NVS, 1'b0));
    pending_reqs.push_back(mk_add(48'h80000, 49'h3000, KIND_UNUSABLE, 1'b0));
    pending_reqs.push_back(mk_add(48'h81000, 49'h5000, KIND_ACPI, 1'b0));
    pending_reqs.push_back(mk_add(48'h7F000, 49'h8000, KIND_RAM, 1'b0));
    pending_reqs.push_back(mk_add(48'h90000, 49'h1000, KIND_VENDOR, 1'b1));
    pending_reqs.push_back(mk_add(48'hA0000, 49'h1000, KIND_TABLE, 1'b0));
    pending_reqs.push_back(mk_add(48'hFFFF_FFFF_F000, 49'h1000, KIND_RAM, 1'b0));
    pending_reqs.push_back(mk_add(48'hFFFF_FFFF_FFFF, 49'h1000, KIND_RAM, 1'b1));
    pending_reqs.push_back(mk_add(48'hFFFF_0000_0000, 49'h1_FFFF_FFFF_FFFF, KIND_NVS, 1'b1));
    pending_reqs.push_back(mk_add(48'h0, 49'h1_0000_0000_0000, KIND_RESERVED, 1'b0));
    pending_reqs.push_back(mk_add(48'h0, 49'h1_0000_0000_0000, KIND_RAM, 1'b1));
    pending_reqs.push_back(mk_other(OP_READ, 5'd0));
    pending_reqs.push_back(mk_other(OP_READ, 5'd31));
    pending_reqs.push_back(mk_other(OP_NOP, 5'd3));
    pending_reqs.push_back(mk_other(OP_CLEAR, 5'd0));
    // Fill the table to force the full status
    for (int k = 0; k < 34; k++)
      pending_reqs.push_back(mk_add(48'(k) << 13, 49'h1000, KIND_RAM, 1'b0));
    pending_reqs.push_back(mk_add(48'h1000, 49'h3F000, KIND_NVS, 1'b0));
    for (int k = 0; k < 32; k++) pending_reqs.push_back(mk_other(OP_READ, 5'(k)));
    pending_reqs.push_back(mk_other(OP_CLEAR, 5'd0));
    wait_drained();

    // Receiver holds off while requests queue up; once everything is back, the sender pauses
    recv_hold = 1'b1;
    for (int k = 0; k < 20; k++) pending_reqs.push_back(rand_req());
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();
    send_pause = 1'b1;
    repeat (20) @(posedge clk);
    send_pause = 1'b0;

    // Random phases with different idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 7 : 0;
      for (int k = 0; k < 520; k++) pending_reqs.push_back(rand_req());
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/mrm_pkg.sv
src/mrm_ram.sv
src/mrm_alu.sv
src/memory_region_map_merge.sv
bench/tb_top.sv
